@@ rtl/core/tree_lca_binary_lifting_top_defines.svh @@
// Assertion macros of the tree LCA block.
// Depends on nothing; included by tlbl_dp, the module that carries assertions.
`ifndef TREE_LCA_BINARY_LIFTING_TOP_DEFINES_SVH
`define TREE_LCA_BINARY_LIFTING_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLBL_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLBL_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tlbl_pkg.sv @@
// Shared types and constants of the tree LCA block.
// No dependencies; used by the interfaces, the controller and the datapath.
`default_nettype none

package tlbl_pkg;

    localparam int NODE_W = 6;
    localparam int CNT_W  = 7;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_ANC  = 2'd1;
    localparam logic [1:0] ACT_PATH = 2'd2;

    typedef enum logic [5:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_CLR,
        OP_ROOT,
        OP_POP,
        OP_UGET,
        OP_DGET,
        OP_EREAD,
        OP_ECHK,
        OP_LINIT,
        OP_LRD1,
        OP_LMID,
        OP_LWR,
        OP_BDONE,
        OP_EMIT_ERR,
        OP_EMIT_NONE,
        OP_DRDA,
        OP_DGETA,
        OP_DGETB,
        OP_LFTRD,
        OP_LFTUP,
        OP_KINC,
        OP_WSELF,
        OP_JSET,
        OP_JRDU,
        OP_JGETU,
        OP_JCMP,
        OP_FRD,
        OP_FGET,
        OP_CURB,
        OP_CURA,
        OP_PUSH,
        OP_CURUP,
        OP_EMIT_CUR,
        OP_EMIT_W,
        OP_SRD,
        OP_EMIT_S
    } dp_op_t;

    typedef struct packed {
        logic   take;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic       fire;
        logic [1:0] in_act;
        logic       in_last;
        logic [1:0] act;
        logic       rerr;
        logic       unreach;
        logic       out_free;
        logic       vlast;
        logic       q_empty;
        logic       e_zero;
        logic       e_last;
        logic       tab_ok;
        logic       lvl_last;
        logic       dbit;
        logic       k_last;
        logic       k_zero;
        logic       uv_eq;
        logic       cur_eq_w;
        logic       sp_zero;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/tlbl_ifs.sv @@
// Channel interfaces of the tree LCA block: request, result and configuration.
// Depends on tlbl_pkg for the field widths.
`default_nettype none

interface tlbl_item_if import tlbl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              last_edge;

    modport source (output valid, action, node_a, node_b, last_edge, input ready);
    modport sink (input valid, action, node_a, node_b, last_edge, output ready);
endinterface

interface tlbl_result_if import tlbl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node;
    logic              none;
    logic              error;
    logic              last;

    modport source (output valid, node, none, error, last, input ready);
    modport sink (input valid, node, none, error, last, output ready);
endinterface

interface tlbl_cfg_if import tlbl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tlbl_ctrl.sv @@
// Sequencing state machine of the tree LCA block.
// Depends on tlbl_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module tlbl_ctrl import tlbl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [31:0] {
        S_IDLE  = 32'h0000_0001,
        S_BCLR  = 32'h0000_0002,
        S_BROOT = 32'h0000_0004,
        S_WPOP  = 32'h0000_0008,
        S_WQ    = 32'h0000_0010,
        S_WDEP  = 32'h0000_0020,
        S_WERD  = 32'h0000_0040,
        S_WECHK = 32'h0000_0080,
        S_LRD1  = 32'h0000_0100,
        S_LMID  = 32'h0000_0200,
        S_LWR   = 32'h0000_0400,
        S_BDONE = 32'h0000_0800,
        S_QCHK  = 32'h0000_1000,
        S_QDB   = 32'h0000_2000,
        S_QDC   = 32'h0000_4000,
        S_LFT   = 32'h0000_8000,
        S_LFTW  = 32'h0001_0000,
        S_CMPS  = 32'h0002_0000,
        S_JRU   = 32'h0004_0000,
        S_JRV   = 32'h0008_0000,
        S_JCMP  = 32'h0010_0000,
        S_FIN   = 32'h0020_0000,
        S_FINW  = 32'h0040_0000,
        S_RES   = 32'h0080_0000,
        S_DN    = 32'h0100_0000,
        S_DNW   = 32'h0200_0000,
        S_UP    = 32'h0400_0000,
        S_UPW   = 32'h0800_0000,
        S_WEMIT = 32'h1000_0000,
        S_POPR  = 32'h2000_0000,
        S_POPW  = 32'h4000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.take   = 1'b0;
        cmd.op     = OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                cmd.op   = OP_ACCEPT;
                if (stat.fire)
                begin
                    case (stat.in_act)
                        ACT_LOAD:          state_next = stat.in_last ? S_BCLR : S_IDLE;
                        ACT_ANC, ACT_PATH: state_next = S_QCHK;
                        default:           state_next = S_IDLE;
                    endcase
                end
            end
            S_BCLR:
            begin
                cmd.op = OP_CLR;
                if (stat.vlast)
                    state_next = S_BROOT;
            end
            S_BROOT:
            begin
                cmd.op     = OP_ROOT;
                state_next = S_WPOP;
            end
            S_WPOP:
            begin
                if (stat.q_empty)
                begin
                    cmd.op     = OP_LINIT;
                    state_next = S_LRD1;
                end
                else
                begin
                    cmd.op     = OP_POP;
                    state_next = S_WQ;
                end
            end
            S_WQ:
            begin
                cmd.op     = OP_UGET;
                state_next = S_WDEP;
            end
            S_WDEP:
            begin
                cmd.op     = OP_DGET;
                state_next = stat.e_zero ? S_WPOP : S_WERD;
            end
            S_WERD:
            begin
                cmd.op     = OP_EREAD;
                state_next = S_WECHK;
            end
            S_WECHK:
            begin
                cmd.op     = OP_ECHK;
                state_next = stat.e_last ? S_WPOP : S_WERD;
            end
            S_LRD1:
            begin
                cmd.op     = OP_LRD1;
                state_next = S_LMID;
            end
            S_LMID:
            begin
                cmd.op = OP_LMID;
                if (stat.tab_ok)
                    state_next = S_LWR;
                else
                    state_next = stat.lvl_last ? S_BDONE : S_LRD1;
            end
            S_LWR:
            begin
                cmd.op     = OP_LWR;
                state_next = stat.lvl_last ? S_BDONE : S_LRD1;
            end
            S_BDONE:
            begin
                cmd.op     = OP_BDONE;
                state_next = S_IDLE;
            end
            S_QCHK:
            begin
                if (stat.rerr)
                begin
                    if (stat.out_free)
                    begin
                        cmd.op     = OP_EMIT_ERR;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.unreach)
                begin
                    if (stat.out_free)
                    begin
                        cmd.op     = OP_EMIT_NONE;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.op     = OP_DRDA;
                    state_next = S_QDB;
                end
            end
            S_QDB:
            begin
                cmd.op     = OP_DGETA;
                state_next = S_QDC;
            end
            S_QDC:
            begin
                cmd.op     = OP_DGETB;
                state_next = S_LFT;
            end
            S_LFT:
            begin
                if (stat.dbit)
                begin
                    cmd.op     = OP_LFTRD;
                    state_next = S_LFTW;
                end
                else if (stat.k_last)
                    state_next = S_CMPS;
                else
                    cmd.op = OP_KINC;
            end
            S_LFTW:
            begin
                cmd.op     = OP_LFTUP;
                state_next = stat.k_last ? S_CMPS : S_LFT;
            end
            S_CMPS:
            begin
                if (stat.uv_eq)
                begin
                    cmd.op     = OP_WSELF;
                    state_next = S_RES;
                end
                else
                begin
                    cmd.op     = OP_JSET;
                    state_next = S_JRU;
                end
            end
            S_JRU:
            begin
                cmd.op     = OP_JRDU;
                state_next = S_JRV;
            end
            S_JRV:
            begin
                cmd.op     = OP_JGETU;
                state_next = S_JCMP;
            end
            S_JCMP:
            begin
                cmd.op     = OP_JCMP;
                state_next = stat.k_zero ? S_FIN : S_JRU;
            end
            S_FIN:
            begin
                cmd.op     = OP_FRD;
                state_next = S_FINW;
            end
            S_FINW:
            begin
                cmd.op     = OP_FGET;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (stat.act == ACT_PATH)
                begin
                    cmd.op     = OP_CURB;
                    state_next = S_DN;
                end
                else if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_W;
                    state_next = S_IDLE;
                end
            end
            // The leg below the ancestor is stacked first so that the last flag
            // of the whole path is known when the ancestor itself goes out.
            S_DN:
            begin
                if (stat.cur_eq_w)
                begin
                    cmd.op     = OP_CURA;
                    state_next = S_UP;
                end
                else
                begin
                    cmd.op     = OP_PUSH;
                    state_next = S_DNW;
                end
            end
            S_DNW:
            begin
                if (stat.tab_ok)
                begin
                    cmd.op     = OP_CURUP;
                    state_next = S_DN;
                end
                else
                begin
                    cmd.op     = OP_CURA;
                    state_next = S_UP;
                end
            end
            S_UP:
            begin
                if (stat.cur_eq_w)
                    state_next = S_WEMIT;
                else if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_CUR;
                    state_next = S_UPW;
                end
            end
            S_UPW:
            begin
                if (stat.tab_ok)
                begin
                    cmd.op     = OP_CURUP;
                    state_next = S_UP;
                end
                else
                    state_next = S_WEMIT;
            end
            S_WEMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_W;
                    state_next = stat.sp_zero ? S_IDLE : S_POPR;
                end
            end
            S_POPR:
            begin
                cmd.op     = OP_SRD;
                state_next = S_POPW;
            end
            S_POPW:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT_S;
                    state_next = stat.sp_zero ? S_IDLE : S_POPR;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/tlbl_dp.sv @@
// Datapath of the tree LCA block: edge store, walk queue, depth and ancestor
// memories, path stack, node counter register and the result register.
// Depends on tlbl_pkg, the channel interfaces and the assertion macro header.
`default_nettype none
`include "tree_lca_binary_lifting_top_defines.svh"

module tlbl_dp import tlbl_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int LEVELS    = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    tlbl_item_if.sink          item,
    tlbl_result_if.source      result,
    tlbl_cfg_if.sink           cfg
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int KW  = $clog2(LEVELS);
    localparam int WW  = ((NW > NODE_W) ? NW : NODE_W) + 1;
    localparam int PW  = NW + 1;
    localparam int CAP = MAX_NODES - 1;
    localparam int TD  = LEVELS << NW;
    localparam int TAW = KW + NW;
    localparam int EDW = 2 * NODE_W;

    localparam logic [NW-1:0] V_LAST = NW'(MAX_NODES - 1);
    localparam logic [NW-1:0] E_CAP  = NW'(CAP);
    localparam logic [KW-1:0] K_LAST = KW'(LEVELS - 1);
    localparam logic [PW-1:0] P_MAX  = PW'(MAX_NODES);

    // Memories. A table entry is {valid, ancestor}.
    logic [EDW-1:0] edge_mem  [0:CAP-1];
    logic [NW:0]    tab_mem   [0:TD-1];
    logic [NW-1:0]  depth_mem [0:MAX_NODES-1];
    logic [NW-1:0]  queue_mem [0:MAX_NODES-1];
    logic [NW-1:0]  stack_mem [0:MAX_NODES-1];

    logic [EDW-1:0] edata_reg;
    logic [NW:0]    tdata_reg;
    logic [NW-1:0]  ddata_reg;
    logic [NW-1:0]  qdata_reg;
    logic [NW-1:0]  sdata_reg;

    // Control registers.
    logic [CNT_W-1:0]     ncnt_reg,  ncnt_next;
    logic [NW-1:0]        total_reg, total_next;
    logic [MAX_NODES-1:0] reached_reg, reached_next;
    logic [PW-1:0]        head_reg, head_next;
    logic [PW-1:0]        tail_reg, tail_next;
    logic [PW-1:0]        sp_reg, sp_next;
    logic [NW-1:0]        e_reg, e_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [NW-1:0]        vc_reg, vc_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload registers.
    logic [1:0]        act_reg, act_next;
    logic              rerr_reg, rerr_next;
    logic [NW-1:0]     a_reg, a_next;
    logic [NW-1:0]     b_reg, b_next;
    logic [NW-1:0]     u_reg, u_next;
    logic [NW-1:0]     v_reg, v_next;
    logic [NW-1:0]     w_reg, w_next;
    logic [NW-1:0]     cur_reg, cur_next;
    logic [NW-1:0]     du_reg, du_next;
    logic [NW-1:0]     da_reg, da_next;
    logic [NW-1:0]     diff_reg, diff_next;
    logic [NW:0]       tu_reg, tu_next;
    logic [NODE_W-1:0] onode_reg, onode_next;
    logic              onone_reg, onone_next;
    logic              oerr_reg, oerr_next;
    logic              olast_reg, olast_next;

    // Memory port controls.
    logic            t_we, t_re;
    logic [TAW-1:0]  t_wa, t_ra;
    logic [NW:0]     t_wd;
    logic            d_we, d_re;
    logic [NW-1:0]   d_wa, d_ra, d_wd;
    logic            q_we, q_re;
    logic [NW-1:0]   q_wa, q_ra, q_wd;
    logic            s_we, s_re;
    logic [NW-1:0]   s_wa, s_ra;
    logic            e_we, e_re;

    logic              fire;
    logic              emit;
    logic              out_free;
    logic [WW-1:0]     n_use;
    logic [NODE_W-1:0] ea, eb, oth;
    logic [NW-1:0]     oth_idx;
    logic              hit_a, hit_b, link_ok;
    logic              tab_ok;
    logic [NW-1:0]     tval;

    assign item.ready = cmd.take;
    assign fire       = item.valid && cmd.take;
    assign cfg.ready  = 1'b1;
    assign out_free   = !out_valid_reg || result.ready;
    assign emit       = (cmd.op == OP_EMIT_ERR) || (cmd.op == OP_EMIT_NONE) ||
                        (cmd.op == OP_EMIT_W) || (cmd.op == OP_EMIT_CUR) ||
                        (cmd.op == OP_EMIT_S);

    assign n_use = (WW'(ncnt_reg) > WW'(MAX_NODES)) ? WW'(MAX_NODES) : WW'(ncnt_reg);

    assign tab_ok = tdata_reg[NW];
    assign tval   = tdata_reg[NW-1:0];

    // Edge check during the walk: the far endpoint of an edge touching u.
    assign ea      = edata_reg[EDW-1:NODE_W];
    assign eb      = edata_reg[NODE_W-1:0];
    assign hit_a   = (WW'(ea) == WW'(u_reg));
    assign hit_b   = (WW'(eb) == WW'(u_reg));
    assign oth     = hit_a ? eb : ea;
    assign oth_idx = NW'(oth);
    assign link_ok = (hit_a || hit_b) && (WW'(oth) < n_use) && !reached_reg[oth_idx];

    always_comb
    begin
        stat.fire     = fire;
        stat.in_act   = item.action;
        stat.in_last  = item.last_edge;
        stat.act      = act_reg;
        stat.rerr     = rerr_reg;
        stat.unreach  = !reached_reg[a_reg] || !reached_reg[b_reg];
        stat.out_free = out_free;
        stat.vlast    = (vc_reg == V_LAST);
        stat.q_empty  = (head_reg == tail_reg);
        stat.e_zero   = (total_reg == '0);
        stat.e_last   = (e_reg == total_reg - NW'(1));
        stat.tab_ok   = tab_ok;
        stat.lvl_last = (k_reg == K_LAST) && (vc_reg == V_LAST);
        stat.dbit     = ((diff_reg >> k_reg) & NW'(1)) != '0;
        stat.k_last   = (k_reg == K_LAST);
        stat.k_zero   = (k_reg == '0);
        stat.uv_eq    = (u_reg == v_reg);
        stat.cur_eq_w = (cur_reg == w_reg);
        stat.sp_zero  = (sp_reg == '0);
    end

    always_comb
    begin
        ncnt_next      = ncnt_reg;
        total_next     = total_reg;
        reached_next   = reached_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        sp_next        = sp_reg;
        e_next         = e_reg;
        k_next         = k_reg;
        vc_next        = vc_reg;
        act_next       = act_reg;
        rerr_next      = rerr_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        cur_next       = cur_reg;
        du_next        = du_reg;
        da_next        = da_reg;
        diff_next      = diff_reg;
        tu_next        = tu_reg;
        onode_next     = onode_reg;
        onone_next     = onone_reg;
        oerr_next      = oerr_reg;
        olast_next     = olast_reg;
        out_valid_next = out_valid_reg && !result.ready;

        t_we = 1'b0; t_wa = '0; t_wd = '0; t_re = 1'b0; t_ra = '0;
        d_we = 1'b0; d_wa = '0; d_wd = '0; d_re = 1'b0; d_ra = '0;
        q_we = 1'b0; q_wa = '0; q_wd = '0; q_re = 1'b0; q_ra = '0;
        s_we = 1'b0; s_wa = '0; s_re = 1'b0; s_ra = '0;
        e_we = 1'b0; e_re = 1'b0;

        if (cfg.valid)
            ncnt_next = cfg.data;

        case (cmd.op)
            OP_ACCEPT:
            begin
                if (fire)
                begin
                    act_next  = item.action;
                    a_next    = NW'(item.node_a);
                    b_next    = NW'(item.node_b);
                    rerr_next = (WW'(item.node_a) >= n_use) || (WW'(item.node_b) >= n_use);
                    sp_next   = '0;
                    if (item.action == ACT_LOAD && total_reg != E_CAP)
                    begin
                        e_we       = 1'b1;
                        total_next = total_reg + NW'(1);
                    end
                end
            end
            OP_CLR:
            begin
                t_we         = 1'b1;
                t_wa         = {KW'(0), vc_reg};
                reached_next = '0;
                vc_next      = vc_reg + NW'(1);
            end
            OP_ROOT:
            begin
                head_next = '0;
                if (n_use != '0)
                begin
                    reached_next[0] = 1'b1;
                    d_we            = 1'b1;
                    q_we            = 1'b1;
                    tail_next       = PW'(1);
                end
                else
                    tail_next = '0;
            end
            OP_POP:
            begin
                q_re      = 1'b1;
                q_ra      = head_reg[NW-1:0];
                head_next = head_reg + PW'(1);
            end
            OP_UGET:
            begin
                u_next = qdata_reg;
                d_re   = 1'b1;
                d_ra   = qdata_reg;
                e_next = '0;
            end
            OP_DGET:
                du_next = ddata_reg;
            OP_EREAD:
                e_re = 1'b1;
            OP_ECHK:
            begin
                e_next = e_reg + NW'(1);
                if (link_ok)
                begin
                    reached_next[oth_idx] = 1'b1;
                    t_we = 1'b1;
                    t_wa = {KW'(0), oth_idx};
                    t_wd = {1'b1, u_reg};
                    d_we = 1'b1;
                    d_wa = oth_idx;
                    d_wd = du_reg + NW'(1);
                    if (tail_reg < P_MAX)
                    begin
                        q_we      = 1'b1;
                        q_wa      = tail_reg[NW-1:0];
                        q_wd      = oth_idx;
                        tail_next = tail_reg + PW'(1);
                    end
                end
            end
            OP_LINIT:
            begin
                k_next  = KW'(1);
                vc_next = '0;
            end
            OP_LRD1:
            begin
                t_re = 1'b1;
                t_ra = {k_reg - KW'(1), vc_reg};
            end
            OP_LMID, OP_LWR:
            begin
                if (cmd.op == OP_LMID && tab_ok)
                begin
                    t_re = 1'b1;
                    t_ra = {k_reg - KW'(1), tval};
                end
                else
                begin
                    t_we = 1'b1;
                    t_wa = {k_reg, vc_reg};
                    t_wd = (cmd.op == OP_LWR) ? tdata_reg : '0;
                    if (vc_reg == V_LAST)
                    begin
                        vc_next = '0;
                        k_next  = k_reg + KW'(1);
                    end
                    else
                        vc_next = vc_reg + NW'(1);
                end
            end
            OP_BDONE:
                total_next = '0;
            OP_EMIT_ERR:
            begin
                onode_next = '0;
                onone_next = 1'b0;
                oerr_next  = 1'b1;
                olast_next = 1'b1;
            end
            OP_EMIT_NONE:
            begin
                onode_next = '0;
                onone_next = 1'b1;
                oerr_next  = 1'b0;
                olast_next = 1'b1;
            end
            OP_DRDA:
            begin
                d_re = 1'b1;
                d_ra = a_reg;
            end
            OP_DGETA:
            begin
                da_next = ddata_reg;
                d_re    = 1'b1;
                d_ra    = b_reg;
            end
            OP_DGETB:
            begin
                k_next = '0;
                if (da_reg < ddata_reg)
                begin
                    u_next    = b_reg;
                    v_next    = a_reg;
                    diff_next = ddata_reg - da_reg;
                end
                else
                begin
                    u_next    = a_reg;
                    v_next    = b_reg;
                    diff_next = da_reg - ddata_reg;
                end
            end
            OP_LFTRD, OP_JRDU:
            begin
                t_re = 1'b1;
                t_ra = {k_reg, u_reg};
            end
            OP_LFTUP:
            begin
                if (tab_ok)
                    u_next = tval;
                k_next = k_reg + KW'(1);
            end
            OP_KINC:
                k_next = k_reg + KW'(1);
            OP_WSELF:
                w_next = u_reg;
            OP_JSET:
                k_next = K_LAST;
            OP_JGETU:
            begin
                tu_next = tdata_reg;
                t_re    = 1'b1;
                t_ra    = {k_reg, v_reg};
            end
            OP_JCMP:
            begin
                if (tu_reg[NW] && tab_ok && tu_reg[NW-1:0] != tval)
                begin
                    u_next = tu_reg[NW-1:0];
                    v_next = tval;
                end
                if (k_reg != '0)
                    k_next = k_reg - KW'(1);
            end
            OP_FRD:
            begin
                t_re = 1'b1;
                t_ra = {KW'(0), u_reg};
            end
            OP_FGET:
                w_next = tab_ok ? tval : '0;
            OP_CURB:
                cur_next = b_reg;
            OP_CURA:
                cur_next = a_reg;
            OP_PUSH:
            begin
                if (sp_reg != P_MAX)
                begin
                    s_we    = 1'b1;
                    s_wa    = sp_reg[NW-1:0];
                    sp_next = sp_reg + PW'(1);
                end
                t_re = 1'b1;
                t_ra = {KW'(0), cur_reg};
            end
            OP_CURUP:
                cur_next = tval;
            OP_EMIT_CUR:
            begin
                onode_next = NODE_W'(cur_reg);
                onone_next = 1'b0;
                oerr_next  = 1'b0;
                olast_next = 1'b0;
                t_re       = 1'b1;
                t_ra       = {KW'(0), cur_reg};
            end
            OP_EMIT_W:
            begin
                onode_next = NODE_W'(w_reg);
                onone_next = 1'b0;
                oerr_next  = 1'b0;
                olast_next = (sp_reg == '0);
            end
            OP_SRD:
            begin
                s_re    = 1'b1;
                s_ra    = NW'(sp_reg - PW'(1));
                sp_next = sp_reg - PW'(1);
            end
            OP_EMIT_S:
            begin
                onode_next = NODE_W'(sdata_reg);
                onone_next = 1'b0;
                oerr_next  = 1'b0;
                olast_next = (sp_reg == '0);
            end
            default:
            begin
            end
        endcase

        if (emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncnt_reg      <= CNT_W'(1);
            total_reg     <= '0;
            reached_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            sp_reg        <= '0;
            e_reg         <= '0;
            k_reg         <= '0;
            vc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ncnt_reg      <= ncnt_next;
            total_reg     <= total_next;
            reached_reg   <= reached_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            sp_reg        <= sp_next;
            e_reg         <= e_next;
            k_reg         <= k_next;
            vc_reg        <= vc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        rerr_reg  <= rerr_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
        cur_reg   <= cur_next;
        du_reg    <= du_next;
        da_reg    <= da_next;
        diff_reg  <= diff_next;
        tu_reg    <= tu_next;
        onode_reg <= onode_next;
        onone_reg <= onone_next;
        oerr_reg  <= oerr_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
            edge_mem[total_reg] <= {item.node_a, item.node_b};
        if (e_re)
            edata_reg <= edge_mem[e_reg];
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
            tab_mem[t_wa] <= t_wd;
        if (t_re)
            tdata_reg <= tab_mem[t_ra];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
            depth_mem[d_wa] <= d_wd;
        if (d_re)
            ddata_reg <= depth_mem[d_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            queue_mem[q_wa] <= q_wd;
        if (q_re)
            qdata_reg <= queue_mem[q_ra];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            stack_mem[s_wa] <= cur_reg;
        if (s_re)
            sdata_reg <= stack_mem[s_ra];
    end

    assign result.valid = out_valid_reg;
    assign result.node  = onode_reg;
    assign result.none  = onone_reg;
    assign result.error = oerr_reg;
    assign result.last  = olast_reg;

    `TLBL_ASSERT_NOW(a_emit_slot, clk, rst_n, emit, out_free, "result loaded over a pending result")
    `TLBL_ASSERT_NOW(a_queue_order, clk, rst_n, 1'b1, (head_reg <= tail_reg) && (tail_reg <= P_MAX), "walk queue pointers out of order")
    `TLBL_ASSERT_NOW(a_stack_cap, clk, rst_n, 1'b1, sp_reg <= P_MAX, "path stack overflow")
    `TLBL_ASSERT_NEXT(a_reach_grows, clk, rst_n, (cmd.op == OP_ECHK) && link_ok, $countones(reached_reg) == $past($countones(reached_reg)) + 1, "new tree link did not mark one node reached")

endmodule

`default_nettype wire

@@ rtl/core/tree_lca_binary_lifting_top.sv @@
// Lowest common ancestor over a tree loaded edge by edge, using binary lifting.
//
// Channels: item (requests: load edge, ancestor query, path query), result
// (answers) and cfg (node_count write, taken and used at any cycle).
// All use valid/ready; a transfer happens when both are high on a clock edge.
// One request is worked on at a time; ready is high only between requests.
// An edge load is stored on acceptance. The request flagged last_edge then
// builds the tables: clearing of the MAX_NODES level-0 entries and the
// reached marks, the breadth-first walk that reads every stored edge for
// each reached node, and the fill of the upper LEVELS-1 table levels.
// Ancestor query: depth reads, lifting to equal depth and, unless the nodes
// then meet, joint lifting and a parent read. A path query then stacks the
// leg from node_b up to the ancestor and sends the node_a leg, the ancestor
// and the stacked nodes. Error and unreached answers skip the table reads.
// Results sit in one output register; a stalled receiver holds the block
// before its next result but a finished answer never blocks the next
// request. Reset clears node_count to 1, the edge count and all reached
// marks, so in-range queries before the first build answer none.
`default_nettype none

module tree_lca_binary_lifting_top import tlbl_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int LEVELS    = 7
)
(
    input  logic           clk,
    input  logic           rst_n,
    tlbl_item_if.sink      item,
    tlbl_result_if.source  result,
    tlbl_cfg_if.sink       cfg
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tlbl_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    tlbl_dp
    #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    )
    u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_tree_lca_binary_lifting_top.sv @@
// Self-checking testbench for the tree LCA block: loads trees edge by edge and
// checks ancestor and path answers against an in-bench predictor.
// Depends on tlbl_pkg, tlbl_ifs and tree_lca_binary_lifting_top.
`timescale 1ns / 1ps

module tb_tree_lca_binary_lifting_top;
    import tlbl_pkg::*;

    localparam int NODES      = 64;
    localparam int LVLS       = 7;
    localparam int EDGE_SLOTS = NODES - 1;
    localparam int IDLE_LIMIT = 60000;
    localparam int BUILD_WAIT = 12000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              none;
        logic              error;
        logic              last;
    } answer_t;

    typedef struct {
        bit         is_cfg;
        logic [1:0] act;
        int         a;
        int         b;
        bit         last_edge;
        bit         typed;
        answer_t    ans;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tlbl_item_if   item ();
    tlbl_result_if result ();
    tlbl_cfg_if    cfg ();

    tree_lca_binary_lifting_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    always #5 clk = ~clk;

    // Predictor state.
    int               node_limit = 1;
    logic [NODE_W-1:0] edge_a [EDGE_SLOTS];
    logic [NODE_W-1:0] edge_b [EDGE_SLOTS];
    int               edge_cnt = 0;
    logic [NODE_W-1:0] up_tab [LVLS][NODES];
    bit               up_ok [LVLS][NODES];
    int               depth [NODES];
    bit               reached [NODES];

    answer_t answer_q[$];
    int      err_cnt = 0;
    int      request_cnt = 0;
    int      answer_cnt = 0;
    int      build_cnt = 0;
    bit      quiet = 1'b0;
    bit      long_hold_req = 1'b0;

    task automatic report(input string what);
        err_cnt++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task automatic expect_answer(input answer_t ans);
        answer_q.insert(answer_q.size(), ans);
    endtask

    function automatic int nodes_used();
        return node_limit > NODES ? NODES : node_limit;
    endfunction

    task automatic build_tree();
        int n;
        int head;
        int tail;
        int u;
        int o;
        int walk [NODES];
        n = nodes_used();
        head = 0;
        tail = 0;
        for (int k = 0; k < LVLS; k++)
            for (int v = 0; v < NODES; v++)
                up_ok[k][v] = 1'b0;
        for (int v = 0; v < NODES; v++)
        begin
            depth[v] = 0;
            reached[v] = 1'b0;
        end
        if (n > 0)
        begin
            reached[0] = 1'b1;
            walk[tail++] = 0;
        end
        while (head < tail)
        begin
            u = walk[head++];
            for (int e = 0; e < edge_cnt; e++)
            begin
                if (edge_a[e] == u)
                    o = edge_b[e];
                else if (edge_b[e] == u)
                    o = edge_a[e];
                else
                    continue;
                if (o >= n || reached[o])
                    continue;
                reached[o] = 1'b1;
                up_tab[0][o] = u[NODE_W-1:0];
                up_ok[0][o] = 1'b1;
                depth[o] = depth[u] + 1;
                if (tail < NODES)
                    walk[tail++] = o;
            end
        end
        for (int k = 1; k < LVLS; k++)
            for (int v = 0; v < NODES; v++)
                if (up_ok[k-1][v])
                begin
                    up_ok[k][v] = up_ok[k-1][up_tab[k-1][v]];
                    up_tab[k][v] = up_tab[k-1][up_tab[k-1][v]];
                end
        edge_cnt = 0;
        build_cnt++;
    endtask

    function automatic int lowest_common(input int u, input int v);
        int t;
        int diff;
        if (depth[u] < depth[v])
        begin
            t = u;
            u = v;
            v = t;
        end
        diff = depth[u] - depth[v];
        for (int k = 0; k < LVLS; k++)
            if (diff[k] && up_ok[k][u])
                u = up_tab[k][u];
        if (u == v)
            return u;
        for (int k = LVLS - 1; k >= 0; k--)
            if (up_ok[k][u] && up_ok[k][v] && up_tab[k][u] != up_tab[k][v])
            begin
                u = up_tab[k][u];
                v = up_tab[k][v];
            end
        return up_ok[0][u] ? up_tab[0][u] : 0;
    endfunction

    function automatic answer_t mk(input int node, input bit nn, input bit er, input bit ls);
        answer_t r;
        r.node = node[NODE_W-1:0];
        r.none = nn;
        r.error = er;
        r.last = ls;
        return r;
    endfunction

    // Updates the tree state for one accepted request and queues its answers.
    task automatic predict_request(input logic [1:0] act, input logic [NODE_W-1:0] a,
                                   input logic [NODE_W-1:0] b, input bit le);
        int n;
        int w;
        int cur;
        int cnt;
        int sp;
        int steps;
        int stack [NODES];
        if (act == ACT_LOAD)
        begin
            if (edge_cnt < EDGE_SLOTS)
            begin
                edge_a[edge_cnt] = a;
                edge_b[edge_cnt] = b;
                edge_cnt++;
            end
            if (le)
                build_tree();
            return;
        end
        if (act == ACT_UNUSED)
            return;
        n = nodes_used();
        if (a >= n || b >= n)
        begin
            expect_answer(mk(0, 0, 1, 1));
            return;
        end
        if (!reached[a] || !reached[b])
        begin
            expect_answer(mk(0, 1, 0, 1));
            return;
        end
        w = lowest_common(a, b);
        if (act == ACT_ANC)
        begin
            expect_answer(mk(w, 0, 0, 1));
            return;
        end
        cnt = 0;
        cur = a;
        steps = 0;
        while (cur != w && steps < NODES && cnt < NODES - 1)
        begin
            expect_answer(mk(cur, 0, 0, 0));
            cnt++;
            steps++;
            if (!up_ok[0][cur])
                break;
            cur = up_tab[0][cur];
        end
        expect_answer(mk(w, 0, 0, 0));
        cnt++;
        sp = 0;
        cur = b;
        steps = 0;
        while (cur != w && steps < NODES && sp < NODES)
        begin
            stack[sp++] = cur;
            steps++;
            if (!up_ok[0][cur])
                break;
            cur = up_tab[0][cur];
        end
        while (sp > 0 && cnt < NODES)
        begin
            sp--;
            expect_answer(mk(stack[sp], 0, 0, 0));
            cnt++;
        end
        answer_q[answer_q.size() - 1].last = 1'b1;
    endtask

    task automatic send_request(input logic [1:0] act, input int a, input int b,
                                input bit le, input bit typed, input answer_t ans);
        item.valid <= 1'b1;
        item.action <= act;
        item.node_a <= a[NODE_W-1:0];
        item.node_b <= b[NODE_W-1:0];
        item.last_edge <= le;
        do
            @(posedge clk);
        while (!item.ready);
        request_cnt++;
        if (typed)
        begin
            // Known answer typed in: advance no state, just expect it.
            expect_answer(ans);
        end
        else
            predict_request(act, a[NODE_W-1:0], b[NODE_W-1:0], le);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send(input logic [1:0] act, input int a, input int b, input bit le);
        send_request(act, a, b, le, 1'b0, '0);
    endtask

    // The node count is only changed once every answer is in and any build is over.
    task automatic write_node_count(input int value);
        item.valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (BUILD_WAIT) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= value[CNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        node_limit = value & 7'h7F;
    endtask

    // Loads a random tree of tree_size nodes, with some stray edges mixed in.
    task automatic load_tree(input int tree_size, input bit overfill);
        int ea [$];
        int eb [$];
        int j;
        int t;
        for (int i = 1; i < tree_size; i++)
        begin
            ea.insert(ea.size(), i);
            eb.insert(eb.size(), $urandom_range(0, i - 1));
            if ($urandom_range(0, 5) == 0)
            begin
                ea.insert(ea.size(), $urandom_range(0, 63));
                eb.insert(eb.size(), $urandom_range(0, 63));
            end
        end
        if (ea.size() == 0 || overfill)
        begin
            ea.insert(ea.size(), $urandom_range(0, 63));
            eb.insert(eb.size(), $urandom_range(0, 63));
        end
        for (int i = ea.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = ea[i]; ea[i] = ea[j]; ea[j] = t;
            t = eb[i]; eb[i] = eb[j]; eb[j] = t;
        end
        for (int i = 0; i < ea.size(); i++)
        begin
            if ($urandom_range(0, 1))
                send(ACT_LOAD, ea[i], eb[i], i == ea.size() - 1);
            else
                send(ACT_LOAD, eb[i], ea[i], i == ea.size() - 1);
        end
    endtask

    task automatic run_queries(input int count);
        int n;
        int a;
        int b;
        n = nodes_used();
        for (int i = 0; i < count; i++)
        begin
            a = (n == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, n - 1);
            b = (n == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, n - 1);
            if ($urandom_range(0, 15) == 0)
                send(ACT_UNUSED, a, b, 1'($urandom_range(0, 1)));
            else
                send($urandom_range(0, 1) ? ACT_PATH : ACT_ANC, a, b, 1'b0);
        end
    endtask

    // Result side: compare every delivered answer and stall at random.
    initial
    begin
        int stall_left;
        answer_t got;
        answer_t want;
        stall_left = 0;
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                answer_cnt++;
                got = {result.node, result.none, result.error, result.last};
                if (answer_q.size() == 0)
                    report($sformatf("answer with nothing pending: %p", got));
                else
                begin
                    want = answer_q.pop_front();
                    if (got.node !== want.node)
                        report($sformatf("node got %0d want %0d", got.node, want.node));
                    if (got.none !== want.none)
                        report($sformatf("none got %b want %b", got.none, want.none));
                    if (got.error !== want.error)
                        report($sformatf("error got %b want %b", got.error, want.error));
                    if (got.last !== want.last)
                        report($sformatf("last got %b want %b", got.last, want.last));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = 400;
                result.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item.valid && item.ready) || (result.valid && result.ready)
                || (cfg.valid && cfg.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        row_t directed [$];
        int counts [6];
        int n;
        item.valid = 1'b0;
        item.action = ACT_LOAD;
        item.node_a = '0;
        item.node_b = '0;
        item.last_edge = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;

        // Before any build nothing is reached; node 1 is out of range at reset.
        directed.insert(directed.size(), '{0, ACT_ANC, 0, 0, 0, 1, mk(0, 1, 0, 1)});
        directed.insert(directed.size(), '{0, ACT_PATH, 0, 0, 0, 1, mk(0, 1, 0, 1)});
        directed.insert(directed.size(), '{0, ACT_ANC, 1, 0, 0, 1, mk(0, 0, 1, 1)});
        directed.insert(directed.size(), '{0, ACT_UNUSED, 63, 63, 1, 0, '0});
        directed.insert(directed.size(), '{1, ACT_LOAD, 64, 0, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_LOAD, 0, 1, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_LOAD, 2, 0, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_LOAD, 1, 3, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_LOAD, 3, 1, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_LOAD, 2, 5, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_LOAD, 5, 63, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_LOAD, 63, 42, 1, 0, '0});
        directed.insert(directed.size(), '{0, ACT_ANC, 3, 5, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_ANC, 42, 3, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_ANC, 0, 0, 0, 1, mk(0, 0, 0, 1)});
        directed.insert(directed.size(), '{0, ACT_PATH, 42, 3, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_PATH, 3, 3, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_ANC, 10, 3, 0, 1, mk(0, 1, 0, 1)});
        directed.insert(directed.size(), '{0, ACT_PATH, 63, 63, 0, 0, '0});
        directed.insert(directed.size(), '{1, ACT_LOAD, 0, 0, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_ANC, 0, 0, 0, 1, mk(0, 0, 1, 1)});
        directed.insert(directed.size(), '{0, ACT_LOAD, 0, 1, 1, 0, '0});
        directed.insert(directed.size(), '{1, ACT_LOAD, 127, 0, 0, 0, '0});
        directed.insert(directed.size(), '{0, ACT_ANC, 0, 1, 0, 1, mk(0, 1, 0, 1)});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                write_node_count(directed[i].a);
            else
                send_request(directed[i].act, directed[i].a, directed[i].b,
                             directed[i].last_edge, directed[i].typed, directed[i].ans);
        end

        // Random trees under a range of node counts; the full tree also overfills.
        counts = '{2, 8, 16, 127, 1, 12};
        foreach (counts[p])
        begin
            write_node_count(counts[p]);
            quiet = (p == 5);
            n = nodes_used();
            if (counts[p] == 127)
            begin
                load_tree(NODES, 1'b1);
                long_hold_req = 1'b1;
                run_queries(8);
            end
            else
            begin
                load_tree($urandom_range(n < 2 ? n : 2, n), 1'b0);
                run_queries(6);
            end
        end
        item.valid <= 1'b0;

        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered %0d requests, %0d tree builds and %0d answers", request_cnt,
                 build_cnt, answer_cnt);
        $display("Node counts swept from 0 to 127, with full 64-node and overfilled trees");
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
